@@ sv/ddgc_pkg.sv @@
// ----------------------------------------------------------------------------
// ddgc_pkg
// shared types, constants and the arctangent table of the go-to-goal controller
// ----------------------------------------------------------------------------
package ddgc_pkg;

  // request payloads
  typedef struct packed {
    logic signed [31:0] pose_east;
    logic signed [31:0] pose_north;
    logic        [15:0] pose_heading;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    logic               arrived;
  } wheel_t;

  // register indexes
  localparam logic [2:0] REG_TARGET_EAST   = 3'd0;
  localparam logic [2:0] REG_TARGET_NORTH  = 3'd1;
  localparam logic [2:0] REG_ARRIVE_TOL    = 3'd2;
  localparam logic [2:0] REG_TURN_GAIN     = 3'd3;
  localparam logic [2:0] REG_TURN_LIMIT    = 3'd4;
  localparam logic [2:0] REG_FWD_LIMIT     = 3'd5;
  localparam logic [2:0] REG_WHEEL_LIMIT   = 3'd6;

  // datapath widths
  localparam int VEC_W   = 36;  // vectoring x/y
  localparam int ROT_W   = 20;  // rotating x/y
  localparam int ROT_ZW  = 34;  // rotating angle

  localparam logic [31:0]        HALF_TURN      = 32'h8000_0000;
  localparam logic [31:0]        NEG_QUARTER    = 32'hC000_0000;
  localparam logic signed [19:0] INV_GAIN_Q16   = 20'sd39797;
  localparam logic signed [43:0] TWO_PI_Q16     = 44'sd411775;
  localparam logic signed [60:0] OMEGA_RND      = 61'sd549755813888;  // 2^39
  localparam logic signed [27:0] DIV_BIAS       = 28'sd62914560;     // 120 * 2^19
  localparam logic [28:0]        RECIP15        = 29'd286331154;     // ceil(2^32 / 15)
  localparam logic signed [20:0] DIV_BIAS_Q     = 21'sd524288;       // 2^19

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051D;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F61E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2E;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2F9;
      5'd15: r = 32'h0000_517C;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A2F;
      5'd19: r = 32'h0000_0517;
      5'd20: r = 32'h0000_028B;
      5'd21: r = 32'h0000_0145;
      5'd22: r = 32'h0000_00A2;
      5'd23: r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

@@ sv/ddgc_vec_cordic.sv @@
// ----------------------------------------------------------------------------
// ddgc_vec_cordic
// pipelined vectoring cordic, one stage per iteration, angle as binary turns
// ----------------------------------------------------------------------------
module ddgc_vec_cordic #(
  parameter int STAGES = 16,
  parameter int SB_W   = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [ddgc_pkg::VEC_W-1:0] x_i,
  input  logic signed [ddgc_pkg::VEC_W-1:0] y_i,
  input  logic        [31:0]                z_i,
  input  logic        [SB_W-1:0]            sb_i,
  output logic                              valid_o,
  output logic        [31:0]                z_o,
  output logic        [SB_W-1:0]            sb_o
);

  logic signed [ddgc_pkg::VEC_W-1:0] x_q [STAGES];
  logic signed [ddgc_pkg::VEC_W-1:0] y_q [STAGES];
  logic        [31:0]                z_q [STAGES];
  logic        [SB_W-1:0]            sb_q [STAGES];
  logic                              v_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [ddgc_pkg::VEC_W-1:0] xin, yin, xs, ys;
    logic        [31:0]                zin, ang;
    logic        [SB_W-1:0]            sbin;
    logic                              vin;

    if (i == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
      assign sbin = sb_i;
      assign vin = valid_i;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
      assign sbin = sb_q[i-1];
      assign vin = v_q[i-1];
    end

    assign xs  = xin >>> i;
    assign ys  = yin >>> i;
    assign ang = ddgc_pkg::atan_turn(5'(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[i] <= sbin;
        if (!yin[ddgc_pkg::VEC_W-1]) begin
          x_q[i] <= xin + ys;
          y_q[i] <= yin - xs;
          z_q[i] <= zin + ang;
        end else begin
          x_q[i] <= xin - ys;
          y_q[i] <= yin + xs;
          z_q[i] <= zin - ang;
        end
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign z_o     = z_q[STAGES-1];
  assign sb_o    = sb_q[STAGES-1];

endmodule

@@ sv/ddgc_rot_cordic.sv @@
// ----------------------------------------------------------------------------
// ddgc_rot_cordic
// pipelined rotating cordic, yields the cosine of the input angle in q16
// ----------------------------------------------------------------------------
module ddgc_rot_cordic #(
  parameter int STAGES = 16,
  parameter int SB_W   = 26
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [ddgc_pkg::ROT_ZW-1:0] z_i,
  input  logic        [SB_W-1:0]             sb_i,
  output logic                               valid_o,
  output logic signed [ddgc_pkg::ROT_W-1:0]  x_o,
  output logic        [SB_W-1:0]             sb_o
);

  logic signed [ddgc_pkg::ROT_W-1:0]  x_q [STAGES];
  logic signed [ddgc_pkg::ROT_W-1:0]  y_q [STAGES];
  logic signed [ddgc_pkg::ROT_ZW-1:0] z_q [STAGES];
  logic        [SB_W-1:0]             sb_q [STAGES];
  logic                               v_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [ddgc_pkg::ROT_W-1:0]  xin, yin, xs, ys;
    logic signed [ddgc_pkg::ROT_ZW-1:0] zin, ang;
    logic        [SB_W-1:0]             sbin;
    logic                               vin;

    if (i == 0) begin : g_first
      assign xin = ddgc_pkg::ROT_W'(ddgc_pkg::INV_GAIN_Q16);
      assign yin = '0;
      assign zin = z_i;
      assign sbin = sb_i;
      assign vin = valid_i;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
      assign sbin = sb_q[i-1];
      assign vin = v_q[i-1];
    end

    assign xs  = xin >>> i;
    assign ys  = yin >>> i;
    assign ang = $signed({2'b00, ddgc_pkg::atan_turn(5'(i))});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[i] <= sbin;
        if (!zin[ddgc_pkg::ROT_ZW-1]) begin
          x_q[i] <= xin - ys;
          y_q[i] <= yin + xs;
          z_q[i] <= zin - ang;
        end else begin
          x_q[i] <= xin + ys;
          y_q[i] <= yin - xs;
          z_q[i] <= zin + ang;
        end
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign x_o     = x_q[STAGES-1];
  assign sb_o    = sb_q[STAGES-1];

endmodule

@@ sv/diff_drive_goal_controller_core.sv @@
// ----------------------------------------------------------------------------
// diff_drive_goal_controller_core
// go-to-goal step for a differential-drive rover: pose in, wheel rates out
// ----------------------------------------------------------------------------
// Fully pipelined: one pose request is taken every clock while the output is
// not stalled, and each one yields one wheel request. Its depth comes from the
// two cordic chains (bearing, then cosine of the heading error), one register
// stage per iteration, plus the distance test, the two omega multiplies and
// the divide-by-120 reciprocal multiply. The whole pipe moves as one: it
// advances whenever the output register is empty or being taken, so a stall
// at the output holds every stage in place. Registers sit on an apb-style
// port at byte addresses 4*index and must only be written while no request
// is in flight.
// ----------------------------------------------------------------------------
module diff_drive_goal_controller_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // pose requests
  input  logic                   pose_valid_i,
  output logic                   pose_ready_o,
  input  ddgc_pkg::pose_t        pose_i,
  // wheel requests
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output ddgc_pkg::wheel_t       cmd_o,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] target_east_q, target_north_q;
  logic [15:0] arrive_tol_q, turn_gain_q, turn_limit_q, fwd_limit_q;
  logic [14:0] wheel_limit_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_east_q  <= '0;
      target_north_q <= '0;
      arrive_tol_q   <= 16'd6554;
      turn_gain_q    <= 16'd5120;
      turn_limit_q   <= 16'd8192;
      fwd_limit_q    <= 16'd4096;
      wheel_limit_q  <= 15'd10240;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ddgc_pkg::REG_TARGET_EAST:  target_east_q  <= pwdata;
        ddgc_pkg::REG_TARGET_NORTH: target_north_q <= pwdata;
        ddgc_pkg::REG_ARRIVE_TOL:   arrive_tol_q   <= pwdata[15:0];
        ddgc_pkg::REG_TURN_GAIN:    turn_gain_q    <= pwdata[15:0];
        ddgc_pkg::REG_TURN_LIMIT:   turn_limit_q   <= pwdata[15:0];
        ddgc_pkg::REG_FWD_LIMIT:    fwd_limit_q    <= pwdata[15:0];
        ddgc_pkg::REG_WHEEL_LIMIT:  wheel_limit_q  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ddgc_pkg::REG_TARGET_EAST:  prdata = target_east_q;
      ddgc_pkg::REG_TARGET_NORTH: prdata = target_north_q;
      ddgc_pkg::REG_ARRIVE_TOL:   prdata = {16'd0, arrive_tol_q};
      ddgc_pkg::REG_TURN_GAIN:    prdata = {16'd0, turn_gain_q};
      ddgc_pkg::REG_TURN_LIMIT:   prdata = {16'd0, turn_limit_q};
      ddgc_pkg::REG_FWD_LIMIT:    prdata = {16'd0, fwd_limit_q};
      ddgc_pkg::REG_WHEEL_LIMIT:  prdata = {17'd0, wheel_limit_q};
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline advance: the whole pipe moves together
  // --------------------------------------------------------------------------
  logic adv;
  assign adv          = !cmd_valid_o || cmd_ready_i;
  assign pose_ready_o = adv;

  // --------------------------------------------------------------------------
  // s1: displacement to target, exact in 33 bits
  // --------------------------------------------------------------------------
  logic               s1_v_q;
  logic signed [32:0] dx_q, dy_q;
  logic [15:0]        s1_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (adv) s1_v_q <= pose_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q      <= 33'(target_east_q) - 33'(pose_i.pose_east);
      dy_q      <= 33'(target_north_q) - 33'(pose_i.pose_north);
      s1_head_q <= pose_i.pose_heading;
    end
  end

  // --------------------------------------------------------------------------
  // s2: magnitudes, squares for the arrival test, fold into right half plane
  // --------------------------------------------------------------------------
  logic        [32:0] adx, ady;
  logic               s2_v_q, near_q;
  logic        [31:0] sqx_q, sqy_q;
  logic signed [ddgc_pkg::VEC_W-1:0] fx_q, fy_q;
  logic        [31:0] fz_q;
  logic        [15:0] s2_head_q;

  assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      near_q    <= (adx <= {17'd0, arrive_tol_q}) && (ady <= {17'd0, arrive_tol_q});
      sqx_q     <= 32'(adx[15:0]) * 32'(adx[15:0]);
      sqy_q     <= 32'(ady[15:0]) * 32'(ady[15:0]);
      s2_head_q <= s1_head_q;
      if (dx_q[32]) begin
        // half-turn fold
        fx_q <= -ddgc_pkg::VEC_W'(dx_q);
        fy_q <= -ddgc_pkg::VEC_W'(dy_q);
        fz_q <= ddgc_pkg::HALF_TURN;
      end else begin
        fx_q <= ddgc_pkg::VEC_W'(dx_q);
        fy_q <= ddgc_pkg::VEC_W'(dy_q);
        fz_q <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // s3: exact arrival compare against tol squared
  // --------------------------------------------------------------------------
  logic               s3_v_q, s3_arr_q;
  logic signed [ddgc_pkg::VEC_W-1:0] s3_x_q, s3_y_q;
  logic        [31:0] s3_z_q;
  logic        [15:0] s3_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (adv) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_arr_q  <= near_q && ((33'(sqx_q) + 33'(sqy_q)) <=
                              33'(32'(arrive_tol_q) * 32'(arrive_tol_q)));
      s3_x_q    <= fx_q;
      s3_y_q    <= fy_q;
      s3_z_q    <= fz_q;
      s3_head_q <= s2_head_q;
    end
  end

  // --------------------------------------------------------------------------
  // bearing to target
  // --------------------------------------------------------------------------
  logic        bv_v;
  logic [31:0] bearing;
  logic [16:0] bv_sb;

  ddgc_vec_cordic #(
    .STAGES (CORDIC_STAGES),
    .SB_W   (17)
  ) u_bearing (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_v_q),
    .x_i     (s3_x_q),
    .y_i     (s3_y_q),
    .z_i     (s3_z_q),
    .sb_i    ({s3_arr_q, s3_head_q}),
    .valid_o (bv_v),
    .z_o     (bearing),
    .sb_o    (bv_sb)
  );

  // --------------------------------------------------------------------------
  // s4: heading error, wraps naturally in 32 bits (half turn reads negative)
  // --------------------------------------------------------------------------
  logic [31:0] err_d;
  logic        s4_v_q, s4_arr_q, s4_zc_q;
  logic [31:0] err_q;

  assign err_d = bearing - {bv_sb[15:0], 16'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (adv) s4_v_q <= bv_v;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      err_q    <= err_d;
      s4_arr_q <= bv_sb[16];
      // cosine forced to zero at a quarter turn or more either way
      s4_zc_q  <= (err_d[31] ^ err_d[30]) || (err_d == ddgc_pkg::NEG_QUARTER);
    end
  end

  // --------------------------------------------------------------------------
  // cosine of the error; errq rides alongside for the turn rate
  // --------------------------------------------------------------------------
  logic                              rc_v;
  logic signed [ddgc_pkg::ROT_W-1:0] rc_x;
  logic        [25:0]                rc_sb;

  ddgc_rot_cordic #(
    .STAGES (CORDIC_STAGES),
    .SB_W   (26)
  ) u_cosine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_v_q),
    .z_i     (ddgc_pkg::ROT_ZW'($signed(err_q))),
    .sb_i    ({s4_arr_q, s4_zc_q, err_q[31:8]}),
    .valid_o (rc_v),
    .x_o     (rc_x),
    .sb_o    (rc_sb)
  );

  // --------------------------------------------------------------------------
  // p1: errq * 2pi, clipped cosine
  // --------------------------------------------------------------------------
  logic               p1_v_q, p1_arr_q;
  logic signed [43:0] m1_q;
  logic        [16:0] cos_q;
  logic signed [23:0] errq;

  assign errq = $signed(rc_sb[23:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_v_q <= 1'b0;
    else if (adv) p1_v_q <= rc_v;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_arr_q <= rc_sb[25];
      m1_q     <= 44'(errq) * ddgc_pkg::TWO_PI_Q16;
      if (rc_sb[24] || rc_x[ddgc_pkg::ROT_W-1]) begin
        cos_q <= '0;
      end else if (rc_x > ddgc_pkg::ROT_W'(65536)) begin
        cos_q <= 17'd65536;
      end else begin
        cos_q <= rc_x[16:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // p2: times turn gain, forward speed
  // --------------------------------------------------------------------------
  logic               p2_v_q, p2_arr_q;
  logic signed [60:0] m2_q;
  logic        [16:0] p2_lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2_v_q <= 1'b0;
    else if (adv) p2_v_q <= p1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_arr_q <= p1_arr_q;
      m2_q     <= 61'(m1_q) * 61'($signed({1'b0, turn_gain_q}));
      p2_lin_q <= 17'((34'(fwd_limit_q) * 34'(cos_q) + 34'd32768) >> 16);
    end
  end

  // --------------------------------------------------------------------------
  // p3: round and clamp the turn rate
  // --------------------------------------------------------------------------
  logic signed [20:0] om_raw, om_lim;
  logic               p3_v_q, p3_arr_q;
  logic signed [16:0] omega_q;
  logic        [16:0] p3_lin_q;

  assign om_raw = 21'((m2_q + ddgc_pkg::OMEGA_RND) >>> 40);
  assign om_lim = $signed({5'd0, turn_limit_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_v_q <= 1'b0;
    else if (adv) p3_v_q <= p2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_arr_q <= p2_arr_q;
      p3_lin_q <= p2_lin_q;
      if (om_raw > om_lim)       omega_q <= 17'(om_lim);
      else if (om_raw < -om_lim) omega_q <= 17'(-om_lim);
      else                       omega_q <= 17'(om_raw);
    end
  end

  // --------------------------------------------------------------------------
  // p4: kinematics numerators, 120 = wheel radius times 800 over track scale
  // --------------------------------------------------------------------------
  logic signed [27:0] fwd_term, turn_term;
  logic               p4_v_q, p4_arr_q;
  logic signed [27:0] nl_q, nr_q;

  assign fwd_term  = 28'sd200 * $signed({11'd0, p3_lin_q});
  assign turn_term = 28'sd77 * 28'(omega_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p4_v_q <= 1'b0;
    else if (adv) p4_v_q <= p3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_arr_q <= p3_arr_q;
      nl_q     <= fwd_term - turn_term + 28'sd60;
      nr_q     <= fwd_term + turn_term + 28'sd60;
    end
  end

  // --------------------------------------------------------------------------
  // p5: floor divide by 120 = bias, shift by 3, reciprocal multiply by 1/15
  // --------------------------------------------------------------------------
  logic [27:0] bl, br;
  logic [53:0] pl, pr;
  logic        p5_v_q, p5_arr_q;
  logic [19:0] ql_q, qr_q;

  assign bl = 28'(nl_q + ddgc_pkg::DIV_BIAS);
  assign br = 28'(nr_q + ddgc_pkg::DIV_BIAS);
  assign pl = 54'(bl[27:3]) * 54'(ddgc_pkg::RECIP15);
  assign pr = 54'(br[27:3]) * 54'(ddgc_pkg::RECIP15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p5_v_q <= 1'b0;
    else if (adv) p5_v_q <= p4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p5_arr_q <= p4_arr_q;
      ql_q     <= pl[51:32];
      qr_q     <= pr[51:32];
    end
  end

  // --------------------------------------------------------------------------
  // output register: remove bias, saturate, arrival override
  // --------------------------------------------------------------------------
  logic signed [20:0] lq, rq, wlim;
  logic signed [15:0] left_sat, right_sat;
  logic               out_v_q;
  ddgc_pkg::wheel_t   out_q;

  assign lq   = $signed({1'b0, ql_q}) - ddgc_pkg::DIV_BIAS_Q;
  assign rq   = $signed({1'b0, qr_q}) - ddgc_pkg::DIV_BIAS_Q;
  assign wlim = $signed({6'd0, wheel_limit_q});

  always_comb begin
    if (lq > wlim)       left_sat = 16'(wlim);
    else if (lq < -wlim) left_sat = 16'(-wlim);
    else                 left_sat = 16'(lq);
    if (rq > wlim)       right_sat = 16'(wlim);
    else if (rq < -wlim) right_sat = 16'(-wlim);
    else                 right_sat = 16'(rq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= p5_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.arrived    <= p5_arr_q;
      out_q.left_rate  <= p5_arr_q ? 16'sd0 : left_sat;
      out_q.right_rate <= p5_arr_q ? 16'sd0 : right_sat;
    end
  end

  assign cmd_valid_o = out_v_q;
  assign cmd_o       = out_q;

`ifndef SYNTHESIS
  // arrival always commands stopped wheels
  a_arrived_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && cmd_o.arrived |-> cmd_o.left_rate == 16'sd0 && cmd_o.right_rate == 16'sd0)
    else $error("arrived request with nonzero wheel rate");

  // a freshly loaded result respects the wheel limit in force when it was loaded
  a_wheel_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && p5_v_q |=>
      ($signed({1'b0, cmd_o.left_rate[15] ? -cmd_o.left_rate : cmd_o.left_rate}) <=
       $signed({2'b0, $past(wheel_limit_q)})) &&
      ($signed({1'b0, cmd_o.right_rate[15] ? -cmd_o.right_rate : cmd_o.right_rate}) <=
       $signed({2'b0, $past(wheel_limit_q)})))
    else $error("wheel rate beyond saturation limit");
`endif

endmodule
